FILE: rtl/assert_macros.svh
// assertion macros used by jmsp_core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge outside reset
`define JMSP_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("jmsp assertion failed");

// condition that must never be true outside reset
`define JMSP_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("jmsp forbidden condition");

`endif

FILE: rtl/jmsp_pkg.sv
// types, codes and constants of the jpeg marker segment parser
package jmsp_pkg;

    // byte classes
    localparam logic [3:0] CL_HEADER  = 4'd0;
    localparam logic [3:0] CL_FILL    = 4'd1;
    localparam logic [3:0] CL_MARKER  = 4'd2;
    localparam logic [3:0] CL_LENGTH  = 4'd3;
    localparam logic [3:0] CL_PAYLOAD = 4'd4;
    localparam logic [3:0] CL_TIFF    = 4'd5;
    localparam logic [3:0] CL_SCAN    = 4'd6;
    localparam logic [3:0] CL_STUFF   = 4'd7;
    localparam logic [3:0] CL_REJECT  = 4'd8;

    // marker bytes
    localparam logic [7:0] MK_PREFIX   = 8'hff;
    localparam logic [7:0] MK_SOI      = 8'hd8;
    localparam logic [7:0] MK_SOS      = 8'hda;
    localparam logic [7:0] MK_APP1     = 8'he1;
    localparam logic [7:0] MK_RST0     = 8'hd0;
    localparam logic [7:0] MK_RST7     = 8'hd7;
    localparam logic [7:0] MK_EOI      = 8'hd9;
    localparam logic [7:0] MK_STUFF    = 8'h00;

    localparam logic [2:0] SIG_LEN = 3'd6;

    typedef enum logic [9:0] {
        PH_HDR0    = 10'b00_0000_0001,
        PH_HDR1    = 10'b00_0000_0010,
        PH_REJECT  = 10'b00_0000_0100,
        PH_SEEK    = 10'b00_0000_1000,
        PH_CODE    = 10'b00_0001_0000,
        PH_LENHI   = 10'b00_0010_0000,
        PH_LENLO   = 10'b00_0100_0000,
        PH_PAYLOAD = 10'b00_1000_0000,
        PH_SCAN    = 10'b01_0000_0000,
        PH_SCANFF  = 10'b10_0000_0000
    } jmsp_phase_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       start_of_file;
    } jmsp_item_t;

    typedef struct packed {
        logic [3:0]  byte_class;
        logic [7:0]  current_marker;
        logic [15:0] payload_left;
        logic        exif_seen;
        logic        header_error;
    } jmsp_result_t;

    // exif signature 45 78 69 66 00 00
    function automatic logic [7:0] exif_sig_byte(input logic [2:0] idx);
        logic [7:0] val;
        case (idx)
            3'd0:    val = 8'h45;
            3'd1:    val = 8'h78;
            3'd2:    val = 8'h69;
            3'd3:    val = 8'h66;
            default: val = 8'h00;
        endcase
        return val;
    endfunction

endpackage

FILE: rtl/jmsp_in_stage.sv
// input register stage holding one accepted item
module jmsp_in_stage
    import jmsp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // data_byte
    input  logic       s_tuser,   // start_of_file
    output logic       item_valid,
    output jmsp_item_t item,
    input  logic       item_take
);

    logic       valid_reg;
    logic       valid_next;
    jmsp_item_t item_reg;
    logic       s_accept;

    assign s_tready   = !valid_reg || item_take;
    assign s_accept   = s_tvalid && s_tready;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (s_accept)
        begin
            valid_next = 1'b1;
        end
        else if (item_take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            item_reg.data_byte     <= s_tdata;
            item_reg.start_of_file <= s_tuser;
        end
    end

endmodule

FILE: rtl/jmsp_core.sv
// parser state, byte classification and result register
`include "assert_macros.svh"

module jmsp_core
    import jmsp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [7:0]   cfg_wdata,
    input  logic         item_valid,
    input  jmsp_item_t   item,
    output logic         item_take,
    output logic         res_valid,
    output jmsp_result_t res,
    input  logic         res_ready
);

    logic [7:0]   exif_marker_reg;
    jmsp_phase_t  phase_reg, phase_next, phase_c;
    logic [7:0]   marker_reg, marker_next, marker_c;
    logic [15:0]  rem_reg, rem_next, rem_c;
    logic [7:0]   lenhi_reg, lenhi_next, lenhi_c;
    logic [2:0]   sig_reg, sig_next, sig_c;
    logic         exif_reg, exif_next, exif_c;
    logic         rej_reg, rej_next, rej_c;
    logic         out_valid_reg, out_valid_next;
    jmsp_result_t res_reg, res_next;

    logic [7:0]   b;
    logic         sof;
    logic [15:0]  len_full;
    logic [3:0]   cls;
    logic         restart_hit;

    assign item_take = item_valid && (!out_valid_reg || res_ready);
    assign res_valid = out_valid_reg;
    assign res       = res_reg;

    assign b   = item.data_byte;
    assign sof = item.start_of_file;

    // start_of_file clears the parser before the byte is taken
    assign phase_c  = sof ? PH_HDR0 : phase_reg;
    assign marker_c = sof ? 8'h00 : marker_reg;
    assign rem_c    = sof ? 16'h0000 : rem_reg;
    assign lenhi_c  = sof ? 8'h00 : lenhi_reg;
    assign sig_c    = sof ? 3'd0 : sig_reg;
    assign exif_c   = sof ? 1'b0 : exif_reg;
    assign rej_c    = sof ? 1'b0 : rej_reg;

    assign len_full = {lenhi_c, b};

    always_comb
    begin
        phase_next  = phase_c;
        marker_next = marker_c;
        rem_next    = rem_c;
        lenhi_next  = lenhi_c;
        sig_next    = sig_c;
        exif_next   = exif_c;
        rej_next    = rej_c;
        cls         = CL_FILL;
        restart_hit = 1'b0;

        unique case (phase_c)
            PH_HDR0:
            begin
                if (b == MK_PREFIX)
                begin
                    cls        = CL_HEADER;
                    phase_next = PH_HDR1;
                end
                else
                begin
                    cls        = CL_REJECT;
                    rej_next   = 1'b1;
                    phase_next = PH_REJECT;
                end
            end
            PH_HDR1:
            begin
                if (b == MK_SOI)
                begin
                    cls        = CL_HEADER;
                    phase_next = PH_SEEK;
                end
                else
                begin
                    cls        = CL_REJECT;
                    rej_next   = 1'b1;
                    phase_next = PH_REJECT;
                end
            end
            PH_REJECT:
            begin
                cls = CL_REJECT;
            end
            PH_CODE:
            begin
                if (b != MK_PREFIX)
                begin
                    cls         = CL_MARKER;
                    marker_next = b;
                    rem_next    = 16'h0000;
                    phase_next  = (b >= MK_RST0 && b <= MK_EOI) ? PH_SEEK : PH_LENHI;
                end
            end
            PH_LENHI:
            begin
                cls        = CL_LENGTH;
                lenhi_next = b;
                phase_next = PH_LENLO;
            end
            PH_LENLO:
            begin
                cls      = CL_LENGTH;
                sig_next = 3'd0;
                // lengths below two give an empty payload
                rem_next = (len_full >= 16'd2) ? (len_full - 16'd2) : 16'h0000;
                if (rem_next != 16'h0000)
                begin
                    phase_next = PH_PAYLOAD;
                end
                else
                begin
                    phase_next = (marker_c == MK_SOS) ? PH_SCAN : PH_SEEK;
                end
            end
            PH_PAYLOAD:
            begin
                cls      = CL_PAYLOAD;
                rem_next = (rem_c != 16'h0000) ? (rem_c - 16'd1) : rem_c;
                if (marker_c == exif_marker_reg)
                begin
                    if (sig_c >= SIG_LEN)
                    begin
                        cls = CL_TIFF;
                    end
                    else if (b == exif_sig_byte(sig_c))
                    begin
                        sig_next = sig_c + 3'd1;
                        if (sig_c == SIG_LEN - 3'd1)
                        begin
                            exif_next = 1'b1;
                        end
                    end
                    else
                    begin
                        // a mismatching byte restarts the match, counting it if it is the first signature byte
                        sig_next = (b == exif_sig_byte(3'd0)) ? 3'd1 : 3'd0;
                    end
                end
                if (rem_next == 16'h0000)
                begin
                    phase_next = (marker_c == MK_SOS) ? PH_SCAN : PH_SEEK;
                end
            end
            PH_SCAN:
            begin
                if (b == MK_PREFIX)
                begin
                    phase_next = PH_SCANFF;
                end
                else
                begin
                    cls = CL_SCAN;
                end
            end
            PH_SCANFF:
            begin
                if (b == MK_STUFF)
                begin
                    cls        = CL_STUFF;
                    phase_next = PH_SCAN;
                end
                else if (b == MK_PREFIX)
                begin
                    cls = CL_FILL;
                end
                else if (b >= MK_RST0 && b <= MK_RST7)
                begin
                    // restart marker stays inside the scan
                    cls         = CL_MARKER;
                    restart_hit = 1'b1;
                    phase_next  = PH_SCAN;
                end
                else
                begin
                    cls         = CL_MARKER;
                    marker_next = b;
                    rem_next    = 16'h0000;
                    phase_next  = (b >= MK_RST0 && b <= MK_EOI) ? PH_SEEK : PH_LENHI;
                end
            end
            default:
            begin
                // seek for the next prefix, also for codes that mean nothing
                cls        = CL_FILL;
                phase_next = (b == MK_PREFIX) ? PH_CODE : PH_SEEK;
            end
        endcase
    end

    always_comb
    begin
        res_next.byte_class     = cls;
        res_next.current_marker = restart_hit ? b : marker_next;
        res_next.payload_left   = rem_next;
        res_next.exif_seen      = exif_next;
        res_next.header_error   = rej_next;
        if (cls == CL_REJECT)
        begin
            res_next.current_marker = 8'h00;
            res_next.payload_left   = 16'h0000;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (item_take)
        begin
            out_valid_next = 1'b1;
        end
        else if (res_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exif_marker_reg <= MK_APP1;
            phase_reg       <= PH_HDR0;
            marker_reg      <= 8'h00;
            rem_reg         <= 16'h0000;
            lenhi_reg       <= 8'h00;
            sig_reg         <= 3'd0;
            exif_reg        <= 1'b0;
            rej_reg         <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                exif_marker_reg <= cfg_wdata;
            end
            if (item_take)
            begin
                phase_reg  <= phase_next;
                marker_reg <= marker_next;
                rem_reg    <= rem_next;
                lenhi_reg  <= lenhi_next;
                sig_reg    <= sig_next;
                exif_reg   <= exif_next;
                rej_reg    <= rej_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_take)
        begin
            res_reg <= res_next;
        end
    end

    `JMSP_ASSERT(a_reject_flagged, clk, rst_n,
        (out_valid_reg && res_reg.byte_class == CL_REJECT) |-> res_reg.header_error)
    `JMSP_ASSERT(a_tiff_after_sig, clk, rst_n,
        (out_valid_reg && res_reg.byte_class == CL_TIFF) |-> res_reg.exif_seen)
    `JMSP_ASSERT(a_marker_no_payload, clk, rst_n,
        (out_valid_reg && res_reg.byte_class == CL_MARKER) |-> res_reg.payload_left == 16'h0000)
    `JMSP_NEVER(a_take_needs_room, clk, rst_n,
        item_take && out_valid_reg && !res_ready)

endmodule

FILE: rtl/jpeg_marker_segment_parser_top.sv
// top level of the jpeg marker segment parser
//
//   channel   dir  handshake          payload
//   s_*       in   s_tvalid/s_tready  tdata: data_byte; tuser: start_of_file
//   m_*       out  m_tvalid/m_tready  tdata: marker, payload_left, flags; tuser: class
//   cfg_*     in   cfg_we             cfg_wdata: exif_app_marker
//
// one item per clock sustained while m_tready is high; input register, then result register
// the parser state updates in the same cycle the item moves into the result register
// a stalled result keeps the input register full and drops s_tready, nothing is lost
// rst_n clears the parser state, both valid flags, and sets exif_app_marker to e1
module jpeg_marker_segment_parser_top
    import jmsp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // start_of_file
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [7:0] current_marker, [23:8] payload_left,
                                   // [24] exif_seen, [25] header_error, rest zero
    output logic [3:0]  m_tuser    // byte_class
);

    logic         item_valid;
    jmsp_item_t   item;
    logic         item_take;
    jmsp_result_t res;

    jmsp_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take)
    );

    jmsp_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take),
        .res_valid  (m_tvalid),
        .res        (res),
        .res_ready  (m_tready)
    );

    assign m_tdata = {6'b000000, res.header_error, res.exif_seen,
                      res.payload_left, res.current_marker};
    assign m_tuser = res.byte_class;

endmodule
